// ----- design/pixel_color_adjust_assert.svh -----
// Assertion macros shared by the pixel color adjust design files.
// Needs no other file; the including module supplies clock and reset names.
`ifndef PIXEL_COLOR_ADJUST_ASSERT_SVH
`define PIXEL_COLOR_ADJUST_ASSERT_SVH
`ifndef ASSERT_OFF
`define PCA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pixel_color_adjust: check failed");
`define PCA_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("pixel_color_adjust: forbidden condition seen");
`else
`define PCA_ASSERT(lbl, clk, rst, prop)
`define PCA_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ----- design/pca_pkg.sv -----
// Package for the pixel color adjust block: configuration types, register
// indexes and the constant tables built at elaboration. Depends on nothing.
package pca_pkg;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS    = 2'd0,
    REG_CONTRAST      = 2'd1,
    REG_SATURATION    = 2'd2,
    REG_INVERSE_GAMMA = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [13:0] brightness;
    logic [15:0]        contrast;
    logic [15:0]        saturation;
  } cfg_t;

  typedef logic [20:0] tab_t [65];
  typedef logic [16:0] scale_tab_t [256];

  localparam logic signed [17:0] LUMA_R = 18'sd13933;
  localparam logic signed [17:0] LUMA_G = 18'sd46871;
  localparam logic signed [17:0] LUMA_B = 18'sd4732;
  localparam int GAMMA_CAP = 20;

  function automatic scale_tab_t pca_scale_tab(input int f);
    scale_tab_t tab;
    int i;
    for (i = 0; i < 256; i++) begin
      tab[i] = 17'((i * (2 << f) + 255) / 510);
    end
    return tab;
  endfunction

  function automatic logic [63:0] pca_isqrt(input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    int j;
    x = xin;
    res = 64'd0;
    bitv = 64'd1 << 62;
    for (j = 0; j < 32; j++) begin
      if (bitv > x) bitv = bitv >> 2;
    end
    for (j = 0; j < 32; j++) begin
      if (bitv != 64'd0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  function automatic tab_t pca_log_tab();
    tab_t tab;
    logic [63:0] x;
    logic [63:0] r;
    int i;
    int b;
    for (i = 0; i <= 64; i++) begin
      x = (64'd1 << 30) + (64'(i) << 24);
      r = 64'd0;
      for (b = 0; b < 20; b++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd1 << 31)) begin
          r = r | 64'd1;
          x = x >> 1;
        end
      end
      tab[i] = 21'((r + 64'd8) >> 4);
    end
    return tab;
  endfunction

  function automatic tab_t pca_exp_tab();
    tab_t tab;
    logic [63:0] q;
    logic [63:0] e;
    int i;
    q = 64'd1 << 29;
    e = 64'd1 << 30;
    for (i = 0; i < 6; i++) begin
      q = pca_isqrt(q << 30);
    end
    tab[0] = 21'd1 << 20;
    for (i = 1; i <= 64; i++) begin
      e = (e * q + (64'd1 << 29)) >> 30;
      tab[i] = 21'((e + 64'd512) >> 10);
    end
    return tab;
  endfunction

endpackage

// ----- design/pca_channels.sv -----
// Valid/ready channel interfaces for source and adjusted pixels.
// Depends on nothing.
interface pca_pixel_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface pca_pixel_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// ----- design/pca_front.sv -----
// Seven pipeline stages: scale to fixed point, contrast, brightness, luma,
// saturation and clamp. Depends on pca_pkg.
module pca_front #(
  parameter int FRAC_BITS = 12
) (
  input  logic                       clk,
  input  logic [6:0]                 en,
  input  pca_pkg::cfg_t              cfg,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,
  output logic [2:0][FRAC_BITS:0]    level
);
  import pca_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int CW = F + 18;
  localparam scale_tab_t SCALE = pca_scale_tab(F);
  localparam logic signed [F+1:0] HALF = (F + 2)'(1) <<< (F - 1);
  localparam logic signed [F+18:0] RND_P = (F + 19)'(1) <<< (F - 1);
  localparam logic signed [CW+19:0] RND_L = (CW + 20)'(1) <<< 15;
  localparam logic signed [CW+17:0] RND_S = (CW + 18)'(1) <<< (F - 1);
  localparam logic signed [CW+18:0] ONE_W = (CW + 19)'(1) <<< F;

  logic [2:0][F:0]              x;
  logic signed [F+18:0]         prod [3];
  logic signed [CW-1:0]         c3 [3];
  logic signed [CW+17:0]        lp [3];
  logic signed [CW-1:0]         c4 [3];
  logic signed [CW-1:0]         c5 [3];
  logic signed [CW-1:0]         luma5;
  logic signed [CW+17:0]        sp [3];
  logic signed [CW-1:0]         luma6;
  logic signed [CW+19:0]        lsum;
  logic signed [CW+18:0]        vv [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x[0] <= SCALE[red][F:0];
      x[1] <= SCALE[green][F:0];
      x[2] <= SCALE[blue][F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod[ch] <= ($signed({1'b0, x[ch]}) - HALF) * $signed({1'b0, cfg.contrast});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int ch = 0; ch < 3; ch++) begin
        c3[ch] <= CW'((prod[ch] + RND_P) >>> F) + CW'(HALF) + CW'(cfg.brightness);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      lp[0] <= c3[0] * LUMA_R;
      lp[1] <= c3[1] * LUMA_G;
      lp[2] <= c3[2] * LUMA_B;
      c4 <= c3;
    end
  end

  assign lsum = (CW + 20)'(lp[0]) + (CW + 20)'(lp[1]) + (CW + 20)'(lp[2]) + RND_L;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      luma5 <= CW'(lsum >>> 16);
      c5 <= c4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int ch = 0; ch < 3; ch++) begin
        sp[ch] <= ((CW + 1)'(c5[ch]) - (CW + 1)'(luma5)) * $signed({1'b0, cfg.saturation});
      end
      luma6 <= luma5;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      vv[ch] = (CW + 19)'(luma6) + (CW + 19)'((sp[ch] + RND_S) >>> F);
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (vv[ch] < 0) begin
          level[ch] <= '0;
        end else if (vv[ch] > ONE_W) begin
          level[ch] <= ONE_W[F:0];
        end else begin
          level[ch] <= vv[ch][F:0];
        end
      end
    end
  end

endmodule

// ----- design/pca_gamma.sv -----
// Seven pipeline stages that raise one clamped channel to the configured
// exponent through log2 and exp2 tables. Depends on pca_pkg.
module pca_gamma #(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic [6:0]           en,
  input  logic [16:0]          ex,
  input  logic [FRAC_BITS:0]   level,
  output logic [7:0]           value
);
  import pca_pkg::*;

  localparam int F = FRAC_BITS;
  localparam tab_t LOG_TAB = pca_log_tab();
  localparam tab_t EXP_TAB = pca_exp_tab();

  logic [4:0]  p;
  logic [16:0] v17;
  logic [16:0] m;
  logic [5:0]  idx8;
  logic [16:0] lt0;
  logic [16:0] ld;
  logic [9:0]  fr8;
  logic [4:0]  p8;
  logic        nz8;
  logic [26:0] lprod;
  logic [17:0] lg;
  logic [20:0] n9;
  logic        nz9;
  logic [38:0] tsum;
  logic [38:0] t10;
  logic        nz10;
  logic [5:0]  idx11;
  logic [20:0] e0;
  logic [20:0] ed;
  logic [9:0]  fr11;
  logic [3:0]  k11;
  logic        zero11;
  logic [30:0] eprod;
  logic [20:0] val12;
  logic [3:0]  k12;
  logic        zero12;
  logic [28:0] prod13;
  logic [3:0]  k13;
  logic        zero13;
  logic [29:0] rsum;
  logic [29:0] rshift;

  assign v17 = 17'(level);

  always_comb begin
    p = '0;
    for (int j = 0; j <= F; j++) begin
      if (level[j]) p = 5'(j);
    end
  end

  assign m = v17 << (5'd16 - p);
  assign idx8 = m[15:10];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lt0 <= LOG_TAB[7'(idx8)][16:0];
      ld  <= LOG_TAB[7'(idx8) + 7'd1][16:0] - LOG_TAB[7'(idx8)][16:0];
      fr8 <= m[9:0];
      p8  <= p;
      nz8 <= (level != '0);
    end
  end

  assign lprod = 27'(ld) * 27'(fr8);
  assign lg = 18'(lt0) + 18'((lprod + 27'd512) >> 10);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      n9  <= 21'((22'(5'(F) - p8) << 16) - 22'(lg));
      nz9 <= nz8;
    end
  end

  assign tsum = (39'(ex) * 39'(n9) + (39'd1 << (F - 1))) >> F;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t10  <= tsum;
      nz10 <= nz9;
    end
  end

  assign idx11 = t10[15:10];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      e0     <= EXP_TAB[7'(idx11)];
      ed     <= EXP_TAB[7'(idx11)] - EXP_TAB[7'(idx11) + 7'd1];
      fr11   <= t10[9:0];
      k11    <= t10[19:16];
      zero11 <= !nz10 || (t10[38:16] > 23'd8);
    end
  end

  assign eprod = 31'(ed) * 31'(fr11);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      val12  <= e0 - 21'((eprod + 31'd512) >> 10);
      k12    <= k11;
      zero12 <= zero11;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      prod13 <= 29'(val12) * 29'd255;
      k13    <= k12;
      zero13 <= zero12;
    end
  end

  assign rsum = 30'(prod13) + (30'd1 << (5'd19 + 5'(k13)));
  assign rshift = rsum >> (5'd20 + 5'(k13));

  always_ff @(posedge clk) begin
    if (en[6]) begin
      if (zero13) begin
        value <= 8'd0;
      end else if (rshift > 30'd255) begin
        value <= 8'd255;
      end else begin
        value <= rshift[7:0];
      end
    end
  end

endmodule

// ----- design/pixel_color_adjust.sv -----
// Channel        | Direction | Contents
// source_pixel   | in        | red_in, green_in, blue_in (8 bits each)
// result_pixel   | out       | red_out, green_out, blue_out, alpha_out
// cfg_we/index   | in        | register writes, data up to 17 bits
// One pixel is accepted every cycle while the output is ready or a stage is
// free, through the fourteen-stage pipeline. Empty stages close up while the
// output is stalled, so a transaction is taken as long as any stage is free.
// Reset is synchronous and clears the valid bits and the registers to their
// defaults. Top level; depends on pca_pkg, pca_channels, pca_front, pca_gamma
// and pixel_color_adjust_assert.svh.
`include "pixel_color_adjust_assert.svh"
module pixel_color_adjust #(
  parameter int FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  pca_pkg::reg_index_t   cfg_index,
  input  logic [16:0]           cfg_data,
  pca_pixel_in_if.sink          source_pixel,
  pca_pixel_out_if.source       result_pixel
);
  import pca_pkg::*;

  localparam int NST = 14;
  localparam logic [21:0] EX_CAP = 22'(GAMMA_CAP) << FRAC_BITS;

  cfg_t              cfg;
  logic [16:0]       inverse_gamma;
  logic [16:0]       ex;
  logic [NST-1:0]    vld;
  logic [NST-1:0]    en;
  logic [2:0][FRAC_BITS:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness <= '0;
      cfg.contrast   <= 16'd1 << FRAC_BITS;
      cfg.saturation <= 16'd1 << FRAC_BITS;
      inverse_gamma  <= 17'd1 << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRIGHTNESS:    cfg.brightness <= cfg_data[13:0];
        REG_CONTRAST:      cfg.contrast   <= cfg_data[15:0];
        REG_SATURATION:    cfg.saturation <= cfg_data[15:0];
        REG_INVERSE_GAMMA: inverse_gamma  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ex = (22'(inverse_gamma) > EX_CAP) ? EX_CAP[16:0] : inverse_gamma;

  always_comb begin
    en[NST-1] = !vld[NST-1] || result_pixel.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= source_pixel.valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign source_pixel.ready = en[0];

  pca_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk   (clk),
    .en    (en[6:0]),
    .cfg   (cfg),
    .red   (source_pixel.red_in),
    .green (source_pixel.green_in),
    .blue  (source_pixel.blue_in),
    .level (level)
  );

  pca_gamma #(.FRAC_BITS(FRAC_BITS)) u_gamma_red (
    .clk   (clk),
    .en    (en[13:7]),
    .ex    (ex),
    .level (level[0]),
    .value (result_pixel.red_out)
  );

  pca_gamma #(.FRAC_BITS(FRAC_BITS)) u_gamma_green (
    .clk   (clk),
    .en    (en[13:7]),
    .ex    (ex),
    .level (level[1]),
    .value (result_pixel.green_out)
  );

  pca_gamma #(.FRAC_BITS(FRAC_BITS)) u_gamma_blue (
    .clk   (clk),
    .en    (en[13:7]),
    .ex    (ex),
    .level (level[2]),
    .value (result_pixel.blue_out)
  );

  assign result_pixel.alpha_out = 8'd255;
  assign result_pixel.valid = vld[NST-1];

  `PCA_ASSERT(a_accept_fills, clk, rst, source_pixel.valid && source_pixel.ready |=> vld[0])
  `PCA_ASSERT(a_full_holds, clk, rst, vld[0] && !en[0] |=> vld[0])
  `PCA_ASSERT(a_out_holds, clk, rst, vld[NST-1] && !result_pixel.ready |=> vld[NST-1])
  `PCA_NEVER(a_no_stall_bubble, clk, rst, !source_pixel.ready && !vld[0])

endmodule

// ----- test/pca_pixel_checker.sv -----
// Checker for the pixel color adjust block: watches both pixel channels and the
// register port, predicts every adjusted pixel and compares. Uses pca_pkg and pca_channels.
module pca_pixel_checker #(
  parameter int FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  pca_pkg::reg_index_t cfg_index,
  input  logic [16:0]         cfg_data,
  pca_pixel_in_if             src,
  pca_pixel_out_if            res,
  output int                  errors,
  output int                  pending
);
  import pca_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  longint          brightness_q;
  longint          contrast_q;
  longint          saturation_q;
  longint unsigned inv_gamma_q;
  longint unsigned log2_tab [65];
  longint unsigned exp2_tab [65];
  pixel_t          expected_pixels [$];

  function automatic longint unsigned root64(input longint unsigned a);
    longint unsigned x;
    longint unsigned r;
    longint unsigned b;
    x = a;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void fill_tables();
    longint unsigned x;
    longint unsigned r;
    longint unsigned q;
    longint unsigned e;
    q = 64'd1 << 29;
    e = 64'd1 << 30;
    for (int i = 0; i <= 64; i++) begin
      x = (64'd1 << 30) + (longint'(i) << 24);
      r = 0;
      for (int b = 0; b < 20; b++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd1 << 31)) begin
          r = r | 1;
          x = x >> 1;
        end
      end
      log2_tab[i] = (r + 8) >> 4;
    end
    for (int i = 0; i < 6; i++) q = root64(q << 30);
    exp2_tab[0] = 64'd1 << 20;
    for (int i = 1; i <= 64; i++) begin
      e = (e * q + (64'd1 << 29)) >> 30;
      exp2_tab[i] = (e + 512) >> 10;
    end
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [7:0] gamma_to_8bit(input longint unsigned v,
                                               input longint unsigned ex);
    int p;
    int idx;
    int k;
    longint unsigned f;
    longint unsigned lg;
    longint unsigned n;
    longint unsigned t;
    longint unsigned val;
    if (v == 0) return 8'd0;
    p = 0;
    while ((v >> (p + 1)) != 0) p++;
    f = (v << (16 - p)) - (64'd1 << 16);
    idx = int'((f >> 10) & 63);
    lg = log2_tab[idx] + (((log2_tab[idx + 1] - log2_tab[idx]) * (f & 1023) + 512) >> 10);
    n = longint'(FRAC_BITS - p) * 65536 - lg;
    t = (ex * n + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if ((t >> 16) > 40) return 8'd0;
    k = int'(t >> 16);
    f = t & 65535;
    idx = int'((f >> 10) & 63);
    val = exp2_tab[idx] - (((exp2_tab[idx] - exp2_tab[idx + 1]) * (f & 1023) + 512) >> 10);
    val = (val * 255 + (64'd1 << (19 + k))) >> (20 + k);
    return (val > 255) ? 8'd255 : val[7:0];
  endfunction

  function automatic pixel_t adjust_pixel(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    longint one;
    longint half;
    longint c [3];
    longint x;
    longint luma;
    longint v;
    longint unsigned ex;
    logic [7:0] chan_in [3];
    logic [7:0] chan_out [3];
    pixel_t px;
    one = longint'(1) << FRAC_BITS;
    half = one >> 1;
    chan_in[0] = r;
    chan_in[1] = g;
    chan_in[2] = b;
    ex = inv_gamma_q;
    if (ex > (longint'(GAMMA_CAP) << FRAC_BITS)) ex = longint'(GAMMA_CAP) << FRAC_BITS;
    for (int ch = 0; ch < 3; ch++) begin
      x = (longint'(chan_in[ch]) * 2 * one + 255) / 510;
      c[ch] = round_shift((x - half) * contrast_q, FRAC_BITS) + half + brightness_q;
    end
    luma = round_shift(c[0] * 13933 + c[1] * 46871 + c[2] * 4732, 16);
    for (int ch = 0; ch < 3; ch++) begin
      v = luma + round_shift((c[ch] - luma) * saturation_q, FRAC_BITS);
      if (v < 0) v = 0;
      if (v > one) v = one;
      chan_out[ch] = gamma_to_8bit(longint'(v), ex);
    end
    px.red = chan_out[0];
    px.green = chan_out[1];
    px.blue = chan_out[2];
    px.alpha = 8'd255;
    return px;
  endfunction

  initial begin
    fill_tables();
  end

  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (rst) begin
      brightness_q <= 0;
      contrast_q <= longint'(1) << FRAC_BITS;
      saturation_q <= longint'(1) << FRAC_BITS;
      inv_gamma_q <= 64'd1 << FRAC_BITS;
      expected_pixels.delete();
      pending <= 0;
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BRIGHTNESS:    brightness_q <= longint'($signed(cfg_data[13:0]));
          REG_CONTRAST:      contrast_q <= longint'(cfg_data[15:0]);
          REG_SATURATION:    saturation_q <= longint'(cfg_data[15:0]);
          REG_INVERSE_GAMMA: inv_gamma_q <= longint'(cfg_data);
          default: ;
        endcase
      end
      if (src.valid && src.ready) begin
        expected_pixels.push_back(adjust_pixel(src.red_in, src.green_in, src.blue_in));
      end
      if (res.valid && res.ready) begin
        got = {res.red_out, res.green_out, res.blue_out, res.alpha_out};
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (want !== got) begin
            $display("%0t: pixel mismatch, expected r%h g%h b%h a%h, actual r%h g%h b%h a%h",
                     $time, want.red, want.green, want.blue, want.alpha,
                     got.red, got.green, got.blue, got.alpha);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_pixels.size();
    end
  end
endmodule

// ----- test/tb_pixel_color_adjust.sv -----
// Testbench top for pixel_color_adjust: drives pixels, register writes and output
// stalls, and reports the verdict. Depends on pca_pkg, pca_channels and pca_pixel_checker.
module tb_pixel_color_adjust;
  import pca_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  reg_index_t cfg_index;
  logic [16:0] cfg_data;
  int         errors;
  int         pending;
  int         quiet_cycles;
  bit         hold_done;

  pca_pixel_in_if  source_pixel ();
  pca_pixel_out_if result_pixel ();

  pixel_color_adjust i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .source_pixel (source_pixel),
    .result_pixel (result_pixel)
  );

  pca_pixel_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src       (source_pixel),
    .res       (result_pixel),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      source_pixel.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    source_pixel.valid <= 1'b1;
    source_pixel.red_in <= r;
    source_pixel.green_in <= g;
    source_pixel.blue_in <= b;
    @(negedge clk);
    while (!source_pixel.ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [16:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic settle();
    source_pixel.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_all(input int bright, input int con, input int sat, input int inv_g);
    settle();
    write_reg(REG_BRIGHTNESS, 17'(bright));
    write_reg(REG_CONTRAST, 17'(con));
    write_reg(REG_SATURATION, 17'(sat));
    write_reg(REG_INVERSE_GAMMA, 17'(inv_g));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_pixels(input int count);
    bit no_gaps;
    logic [7:0] ch [3];
    no_gaps = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 7))
          0: ch[k] = 8'd0;
          1: ch[k] = 8'd255;
          default: ch[k] = 8'($urandom_range(0, 255));
        endcase
      end
      send_pixel(ch[0], ch[1], ch[2], no_gaps);
    end
  endtask

  // Output side: random stalls, stretches without stalls, and one long hold-off.
  initial begin
    int served;
    bit no_gaps;
    int gap;
    served = 0;
    no_gaps = 1'b0;
    hold_done = 1'b0;
    result_pixel.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (served % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (served == 150 && !hold_done) begin
        result_pixel.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        result_pixel.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_pixel.ready <= 1'b1;
      @(negedge clk);
      while (!result_pixel.valid) begin
        @(posedge clk);
        @(negedge clk);
      end
      @(posedge clk);
      served++;
    end
  end

  always @(posedge clk) begin
    if (rst || (source_pixel.valid && source_pixel.ready) ||
        (result_pixel.valid && result_pixel.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == 3000) begin
        $display("[pixel_color_adjust] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_BRIGHTNESS;
    cfg_data <= '0;
    source_pixel.valid <= 1'b0;
    source_pixel.red_in <= '0;
    source_pixel.green_in <= '0;
    source_pixel.blue_in <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd1, 8'd1, 8'd1, 1'b1);
    send_pixel(8'd254, 8'd128, 8'd127, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
    send_pixel(8'hAA, 8'h55, 8'hAA, 1'b1);
    // Exponent zero: nonzero values go to full scale, zero stays zero.
    set_all(0, 4096, 4096, 0);
    send_pixel(8'd0, 8'd1, 8'd200, 1'b0);
    // Exponent above the cap, with tiny powers that fall off the tables.
    set_all(0, 4096, 4096, 131071);
    send_pixel(8'd1, 8'd30, 8'd255, 1'b0);
    send_pixel(8'd254, 8'd250, 8'd128, 1'b0);
    set_all(4096, 65535, 65535, 81920);
    send_pixel(8'd0, 8'd128, 8'd255, 1'b0);
    send_pixel(8'd127, 8'd129, 8'd100, 1'b0);
    set_all(-4096, 0, 0, 1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
    set_all(8191, 0, 65535, 4096);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    set_all(-8192, 65535, 0, 2048);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd200, 8'd90, 8'd10, 1'b0);

    set_all(0, 4096, 4096, 4096);
    random_pixels(200);
    for (int ph = 0; ph < 6; ph++) begin
      set_all($urandom_range(0, 4096) - 2048, $urandom_range(2048, 8192),
              $urandom_range(0, 12288), $urandom_range(1, 20480));
      random_pixels(60);
    end
    set_all(-4096, 65535, 65535, 81920);
    random_pixels(40);
    set_all(4096, 0, 0, 1);
    random_pixels(40);

    source_pixel.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("[pixel_color_adjust] OK");
    end else begin
      $display("[pixel_color_adjust] ERROR");
    end
    $finish;
  end
endmodule
